// File: hw/rtl/fat16rd_pkg.sv
// ============================================================================
// fat16rd_pkg
// Shared types and constants for the FAT16 file read sequencer.
// ============================================================================
package fat16rd_pkg;

    // Request modes
    localparam logic [1:0] MODE_REWIND = 2'd0;
    localparam logic [1:0] MODE_BYTE   = 2'd1;
    localparam logic [1:0] MODE_SECTOR = 2'd2;
    localparam logic [1:0] MODE_FAT    = 2'd3;

    // Result kinds
    localparam logic [2:0] KIND_BYTE   = 3'd0;
    localparam logic [2:0] KIND_SECTOR = 3'd1;
    localparam logic [2:0] KIND_FAT    = 3'd2;
    localparam logic [2:0] KIND_EOF    = 3'd3;
    localparam logic [2:0] KIND_DONE   = 3'd4;
    localparam logic [2:0] KIND_REJECT = 3'd5;

    // Register indexes
    localparam logic [2:0] REG_FAT_START  = 3'd0;
    localparam logic [2:0] REG_DATA_START = 3'd1;
    localparam logic [2:0] REG_SECT_BYTES = 3'd2;
    localparam logic [2:0] REG_CLUS_SECTS = 3'd3;
    localparam logic [2:0] REG_FILE_SIZE  = 3'd4;
    localparam logic [2:0] REG_START_CLUS = 3'd5;

    localparam logic [15:0] CLUSTER_END = 16'hffff;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] fat_entry;
    } req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] sector_address;
        logic [11:0] byte_offset;
        logic        fetch_needed;
        logic        last;
    } res_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } seq_state_t;

endpackage

// File: hw/rtl/fat16rd_front.sv
// ============================================================================
// fat16rd_front
// Front end: two-entry request queue that takes requests from the input side.
// ============================================================================
module fat16rd_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  fat16rd_pkg::req_t   req,
    output logic                q_valid,
    output fat16rd_pkg::req_t   q_req,
    input  logic                q_take
);
    import fat16rd_pkg::*;

    req_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;

    assign full    = (count_reg == 2'd2);
    assign do_push = push && !full;
    assign q_valid = (count_reg != 2'd0);
    assign q_req   = slot_reg[rd_ptr_reg];

    // Payload slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= req;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_take && q_valid)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, q_take && q_valid};
        end
    end

endmodule

// File: hw/rtl/fat16rd_back.sv
// ============================================================================
// fat16rd_back
// Back end: holds the file position, works each request and queues results.
// A restoring divider splits 2*cluster by the sector size on cluster ends.
// ============================================================================
module fat16rd_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                q_valid,
    input  fat16rd_pkg::req_t   q_req,
    output logic                q_take,
    output logic                empty,
    input  logic                pop,
    output fat16rd_pkg::res_t   res
);
    import fat16rd_pkg::*;

    // Configuration
    logic [31:0] fat_start_reg, data_start_reg, file_size_reg;
    logic [12:0] sect_bytes_reg;
    logic [7:0]  clus_sects_reg;
    logic [15:0] start_clus_reg;

    // File state
    logic [15:0] cluster_reg, cluster_next;
    logic [7:0]  sic_reg, sic_next;
    logic [11:0] ois_reg, ois_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] cache_reg, cache_next;
    logic        await_reg, await_next;

    // Sequencer
    seq_state_t  state_reg, state_next;
    logic [4:0]  div_cnt_reg, div_cnt_next;
    logic [16:0] quo_reg, quo_next;
    logic [12:0] rem_reg, rem_next;
    logic [31:0] dsec_reg, dsec_next;
    logic        div_start;

    // Details of the held first result across the divide
    logic        oq_kind_reg;
    logic [11:0] held_off_reg;
    logic        held_fetch_reg;

    // Output queue, two results deep
    res_t        oq_reg [2];
    logic        oq_wr_reg, oq_rd_reg;
    logic [1:0]  oq_cnt_reg;
    logic        w0, w1;
    res_t        r0, r1;

    logic [12:0] sb;
    logic [7:0]  cs;
    logic [31:0] dsec;
    logic [12:0] ois_inc;
    logic [7:0]  sic_inc;
    logic        wrap_sec, clus_end;
    logic [31:0] fs;
    logic [13:0] rem_sh;

    always_comb
    begin
        if (sect_bytes_reg < 13'd2)
            sb = 13'd2;
        else if (sect_bytes_reg > 13'd4096)
            sb = 13'd4096;
        else
            sb = sect_bytes_reg;
        cs = (clus_sects_reg == 8'd0) ? 8'd1 : clus_sects_reg;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fat_start_reg  <= '0;
            data_start_reg <= '0;
            sect_bytes_reg <= 13'd512;
            clus_sects_reg <= 8'd1;
            file_size_reg  <= '0;
            start_clus_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FAT_START:  fat_start_reg  <= cfg_data;
                REG_DATA_START: data_start_reg <= cfg_data;
                REG_SECT_BYTES: sect_bytes_reg <= cfg_data[12:0];
                REG_CLUS_SECTS: clus_sects_reg <= cfg_data[7:0];
                REG_FILE_SIZE:  file_size_reg  <= cfg_data;
                REG_START_CLUS: start_clus_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Data sector address: one multiply on the cluster number
    assign dsec = data_start_reg + ({16'd0, cluster_reg} - 32'd2) * {24'd0, cs}
                + {24'd0, sic_reg};
    assign ois_inc  = {1'b0, ois_reg} + 13'd1;
    assign sic_inc  = sic_reg + 8'd1;
    assign rem_sh   = {rem_reg, quo_reg[16]};
    assign fs       = fat_start_reg + {15'd0, quo_reg};
    assign empty    = (oq_cnt_reg == 2'd0);
    assign res      = oq_reg[oq_rd_reg];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (div_start)
                    state_next = ST_DIV;
            ST_DIV:
                if (div_cnt_reg == 5'd16)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (oq_cnt_reg == 2'd0)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Request handling and outputs
    always_comb
    begin
        cluster_next = cluster_reg;
        sic_next     = sic_reg;
        ois_next     = ois_reg;
        pos_next     = pos_reg;
        cache_next   = cache_reg;
        await_next   = await_reg;
        div_cnt_next = div_cnt_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        dsec_next    = dsec_reg;
        div_start    = 1'b0;
        q_take       = 1'b0;
        w0           = 1'b0;
        w1           = 1'b0;
        r0           = '0;
        r1           = '0;
        wrap_sec     = 1'b0;
        clus_end     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                // needs room for up to two results
                if (q_valid && oq_cnt_reg == 2'd0)
                begin
                    q_take  = 1'b1;
                    r0.last = 1'b1;
                    if (q_req.mode == MODE_REWIND)
                    begin
                        cluster_next = start_clus_reg;
                        sic_next = '0;
                        ois_next = '0;
                        pos_next = '0;
                        await_next = 1'b0;
                        r0.kind = KIND_DONE;
                        w0 = 1'b1;
                    end
                    else if (q_req.mode == MODE_FAT)
                    begin
                        w0 = 1'b1;
                        if (!await_reg)
                            r0.kind = KIND_REJECT;
                        else
                        begin
                            cluster_next = q_req.fat_entry;
                            await_next = 1'b0;
                            r0.kind = KIND_DONE;
                        end
                    end
                    else if (await_reg)
                    begin
                        r0.kind = KIND_REJECT;
                        w0 = 1'b1;
                    end
                    else if (pos_reg == file_size_reg || cluster_reg == CLUSTER_END)
                    begin
                        r0.kind = KIND_EOF;
                        w0 = 1'b1;
                    end
                    else
                    begin
                        r0.sector_address = dsec;
                        if (q_req.mode == MODE_BYTE)
                        begin
                            r0.kind = KIND_BYTE;
                            r0.byte_offset = ois_reg;
                            r0.fetch_needed = (cache_reg != dsec);
                            cache_next = dsec;
                            pos_next = pos_reg + 32'd1;
                            if (ois_inc >= sb)
                            begin
                                ois_next = '0;
                                wrap_sec = 1'b1;
                            end
                            else
                                ois_next = ois_inc[11:0];
                        end
                        else
                        begin
                            r0.kind = KIND_SECTOR;
                            r0.byte_offset = ois_reg;
                            r0.fetch_needed = 1'b1;
                            pos_next = pos_reg + {19'd0, sb};
                            wrap_sec = 1'b1;
                        end
                        if (wrap_sec)
                        begin
                            sic_next = sic_inc;
                            clus_end = (sic_inc == cs);
                        end
                        if (clus_end)
                        begin
                            // hold the first result until the FAT request is ready
                            sic_next  = '0;
                            await_next = 1'b1;
                            r0.last   = 1'b0;
                            dsec_next = dsec;
                            div_start = 1'b1;
                            div_cnt_next = '0;
                            quo_next  = {cluster_reg, 1'b0};
                            rem_next  = '0;
                            cache_next = (q_req.mode == MODE_BYTE) ? dsec : cache_reg;
                            w0 = 1'b0;
                        end
                        else
                            w0 = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                // one quotient bit per cycle
                if ({1'b0, rem_sh} >= {2'b0, sb} || rem_sh[13])
                begin
                    rem_next = rem_sh[12:0] - sb;
                    quo_next = {quo_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[12:0];
                    quo_next = {quo_reg[15:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 5'd1;
            end
            ST_EMIT:
            begin
                if (oq_cnt_reg == 2'd0)
                begin
                    w0 = 1'b1;
                    w1 = 1'b1;
                    r0.kind = (oq_kind_reg == 1'b1) ? KIND_BYTE : KIND_SECTOR;
                    r0.sector_address = dsec_reg;
                    r0.byte_offset = (oq_kind_reg == 1'b1) ? held_off_reg : ois_reg;
                    r0.fetch_needed = (oq_kind_reg == 1'b1) ? held_fetch_reg : 1'b1;
                    r0.last = 1'b0;
                    r1.kind = KIND_FAT;
                    r1.sector_address = fs;
                    r1.byte_offset = rem_reg[11:0];
                    r1.fetch_needed = (cache_reg != fs);
                    r1.last = 1'b1;
                    cache_next = fs;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            oq_kind_reg    <= (q_req.mode == MODE_BYTE);
            held_off_reg   <= ois_reg;
            held_fetch_reg <= r0.fetch_needed;
        end
        div_cnt_reg <= div_cnt_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        dsec_reg    <= dsec_next;
        if (w0)
            oq_reg[oq_wr_reg] <= r0;
        if (w1)
            oq_reg[~oq_wr_reg] <= r1;
    end

    // Control state and file state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cluster_reg <= '0;
            sic_reg     <= '0;
            ois_reg     <= '0;
            pos_reg     <= '0;
            cache_reg   <= '0;
            await_reg   <= 1'b0;
            oq_wr_reg   <= 1'b0;
            oq_rd_reg   <= 1'b0;
            oq_cnt_reg  <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            cluster_reg <= cluster_next;
            sic_reg     <= sic_next;
            ois_reg     <= ois_next;
            pos_reg     <= pos_next;
            cache_reg   <= cache_next;
            await_reg   <= await_next;
            oq_wr_reg   <= oq_wr_reg ^ (w0 ^ w1);
            if (pop && !empty)
                oq_rd_reg <= ~oq_rd_reg;
            oq_cnt_reg  <= oq_cnt_reg + {1'b0, w0} + {1'b0, w1} - {1'b0, pop && !empty};
        end
    end

endmodule

// File: hw/rtl/fat16_file_read_sequencer.sv
// ============================================================================
// fat16_file_read_sequencer
// Read position tracker for one FAT16 file, with queue-style ports.
// ============================================================================
//  channel   | handshake            | payload
//  ----------+----------------------+--------------------------------
//  request   | push / full          | req  (mode, fat_entry)
//  result    | empty / pop          | res  (kind, address, offset, ...)
//  config    | cfg_we               | cfg_index, cfg_data
//
// A request that ends within a cluster is answered from the idle state; one
// that ends a cluster also waits on the bit-serial divide of 2*cluster by the
// sector size. The back end starts a request only when its result queue is
// empty. Reset clears control and file state; the cache tag resets to zero.
module fat16_file_read_sequencer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  fat16rd_pkg::req_t   req,
    output logic                empty,
    input  logic                pop,
    output fat16rd_pkg::res_t   res,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import fat16rd_pkg::*;

    logic q_valid, q_take;
    req_t q_req;

    fat16rd_front u_front
    (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .req(req),
        .q_valid(q_valid), .q_req(q_req), .q_take(q_take)
    );

    fat16rd_back u_back
    (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .q_valid(q_valid), .q_req(q_req), .q_take(q_take),
        .empty(empty), .pop(pop), .res(res)
    );

endmodule

// File: dv/tb_top.sv
// ============================================================================
// tb_top
// Checks the FAT16 file read sequencer against a model of its read position,
// cache tag and FAT wait, over several volume geometries and random requests.
// ============================================================================
module tb_top;
    import fat16rd_pkg::*;

    // Position tracker model and queue of expected results
    class fat_read_scoreboard;
        logic [31:0] fat_start, data_start, file_len;
        logic [12:0] sect_bytes;
        logic [7:0]  clus_sects;
        logic [15:0] first_clus;
        logic [15:0] cur_clus;
        logic [7:0]  sect_idx;
        logic [11:0] byte_idx;
        logic [31:0] file_pos, cache_tag;
        bit          fat_wait;
        res_t        pending[$];
        int          errors;

        function void reset_state();
            fat_start = 0; data_start = 0; sect_bytes = 512; clus_sects = 1;
            file_len = 0; first_clus = 0; cur_clus = 0; sect_idx = 0;
            byte_idx = 0; file_pos = 0; cache_tag = 0; fat_wait = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_FAT_START:  fat_start = v;
                REG_DATA_START: data_start = v;
                REG_SECT_BYTES: sect_bytes = v[12:0];
                REG_CLUS_SECTS: clus_sects = v[7:0];
                REG_FILE_SIZE:  file_len = v;
                REG_START_CLUS: first_clus = v[15:0];
                default: ;
            endcase
        endfunction

        function void add(logic [2:0] k, logic [31:0] a, logic [11:0] o,
                          logic f, logic l);
            res_t r;
            r.kind = k; r.sector_address = a; r.byte_offset = o;
            r.fetch_needed = f; r.last = l;
            pending.push_back(r);
        endfunction

        // Step to the next sector; a finished cluster queues a FAT request
        function bit advance_sector(logic [31:0] sb);
            logic [31:0] cs, twice, fs;
            cs = (clus_sects == 0) ? 1 : clus_sects;
            sect_idx = sect_idx + 1;
            if (sect_idx == cs[7:0])
            begin
                twice = {15'd0, cur_clus, 1'b0};
                fs = fat_start + twice / sb;
                add(KIND_FAT, fs, 12'(twice % sb), cache_tag != fs, 1'b1);
                cache_tag = fs;
                sect_idx = 0;
                fat_wait = 1;
                return 1;
            end
            return 0;
        endfunction

        function void note_request(req_t q);
            logic [31:0] sb, cs, sec, off;
            res_t first;
            bit more;
            if (q.mode == MODE_REWIND)
            begin
                cur_clus = first_clus; sect_idx = 0; byte_idx = 0;
                file_pos = 0; fat_wait = 0;
                add(KIND_DONE, 0, 0, 0, 1);
                return;
            end
            if (q.mode == MODE_FAT)
            begin
                if (fat_wait)
                begin
                    cur_clus = q.fat_entry; fat_wait = 0;
                    add(KIND_DONE, 0, 0, 0, 1);
                end
                else
                    add(KIND_REJECT, 0, 0, 0, 1);
                return;
            end
            if (fat_wait)
            begin
                add(KIND_REJECT, 0, 0, 0, 1);
                return;
            end
            if (file_pos == file_len || cur_clus == CLUSTER_END)
            begin
                add(KIND_EOF, 0, 0, 0, 1);
                return;
            end
            sb = (sect_bytes < 2) ? 2 : (sect_bytes > 4096) ? 4096 : sect_bytes;
            cs = (clus_sects == 0) ? 1 : clus_sects;
            sec = data_start + ({16'd0, cur_clus} - 2) * cs + sect_idx;
            first.kind = (q.mode == MODE_BYTE) ? KIND_BYTE : KIND_SECTOR;
            first.sector_address = sec;
            first.byte_offset = byte_idx;
            first.fetch_needed = (q.mode == MODE_BYTE) ? (cache_tag != sec) : 1'b1;
            more = 0;
            if (q.mode == MODE_BYTE)
            begin
                cache_tag = sec;
                file_pos = file_pos + 1;
                off = byte_idx + 1;
                byte_idx = off[11:0];
                if (off >= sb)
                begin
                    byte_idx = 0;
                    pending.push_back(first);
                    more = advance_sector(sb);
                end
            end
            else
            begin
                file_pos = file_pos + sb;
                pending.push_back(first);
                more = advance_sector(sb);
            end
            if (q.mode == MODE_SECTOR || off >= sb)
            begin
                // first result already queued ahead of any FAT request
                pending[pending.size() - 1 - more].last = !more;
            end
            else
            begin
                first.last = 1;
                pending.push_back(first);
            end
        endfunction

        function void check_result(res_t r);
            res_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result kind %0d", r.kind);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (r.kind !== e.kind)
            begin
                $error("kind exp %0d got %0d", e.kind, r.kind); errors++;
            end
            if (r.sector_address !== e.sector_address)
            begin
                $error("sector_address exp %0h got %0h", e.sector_address,
                       r.sector_address);
                errors++;
            end
            if (r.byte_offset !== e.byte_offset)
            begin
                $error("byte_offset exp %0d got %0d", e.byte_offset, r.byte_offset);
                errors++;
            end
            if (r.fetch_needed !== e.fetch_needed)
            begin
                $error("fetch_needed exp %0b got %0b", e.fetch_needed,
                       r.fetch_needed);
                errors++;
            end
            if (r.last !== e.last)
            begin
                $error("last exp %0b got %0b", e.last, r.last); errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        push = 0;
    logic        full;
    req_t        req = '0;
    logic        empty;
    logic        pop = 0;
    res_t        res;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    bit          quiet = 0;
    fat_read_scoreboard sb_chk = new();

    fat16_file_read_sequencer dut (.*);

    always #5 clk = ~clk;

    // Result side: random stalls, check on each accepted result
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb_chk.check_result(res);
        pop <= quiet || ($urandom_range(99) >= 7);
    end

    // One register write; the caller drops the write enable afterwards
    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
        @(posedge clk);
        sb_chk.set_reg(idx, v);
    endtask

    // Drive one request, with random idle cycles ahead of it
    task automatic send(logic [1:0] m, logic [15:0] e);
        req_t q;
        while (!quiet && $urandom_range(99) < 7)
        begin
            push <= 0;
            @(posedge clk);
        end
        q.mode = m; q.fat_entry = e;
        push <= 1; req <= q;
        do @(posedge clk); while (full);
        sb_chk.note_request(q);
    endtask

    // Wait for all results, then let the divider settle before a write
    task automatic drain();
        push <= 0;
        while (sb_chk.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // A realistic read: bytes/sectors, answering FAT requests, with rare rewinds
    task automatic random_walk(int n);
        for (int i = 0; i < n; i++)
        begin
            int r;
            r = $urandom_range(99);
            if (sb_chk.fat_wait && r < 85)
                send(MODE_FAT, ($urandom_range(9) == 0) ? CLUSTER_END
                                 : 16'($urandom));
            else if (r < 3)
                send(MODE_REWIND, 16'($urandom));
            else if (r < 6)
                send(MODE_FAT, 16'($urandom));
            else if (r < 75)
                send(MODE_BYTE, 16'($urandom));
            else
                send(MODE_SECTOR, 16'($urandom));
        end
    endtask

    task automatic geometry(logic [31:0] fs, logic [31:0] ds, logic [31:0] sbytes,
                            logic [31:0] cs, logic [31:0] len, logic [31:0] clus);
        drain();
        write_reg(REG_FAT_START, fs);
        write_reg(REG_DATA_START, ds);
        write_reg(REG_SECT_BYTES, sbytes);
        write_reg(REG_CLUS_SECTS, cs);
        write_reg(REG_FILE_SIZE, len);
        write_reg(REG_START_CLUS, clus);
        cfg_we <= 0;
    endtask

    initial
    begin
        sb_chk.reset_state();
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: reset state, rejects, EOF at size 0, then small geometry
        send(MODE_BYTE, 16'h0000);
        send(MODE_FAT, 16'hffff);
        send(MODE_SECTOR, 16'h0000);
        geometry(32'hffff_fff0, 32'hffff_ffff, 2, 1, 32'hffff_ffff, 16'hffff);
        send(MODE_REWIND, 0);
        send(MODE_BYTE, 0);
        send(MODE_FAT, 16'h0001);
        send(MODE_BYTE, 0);
        send(MODE_BYTE, 0);
        send(MODE_SECTOR, 0);
        send(MODE_BYTE, 0);
        send(MODE_FAT, 16'hfffe);
        send(MODE_SECTOR, 0);
        send(MODE_FAT, 16'h0000);
        send(MODE_SECTOR, 0);
        send(MODE_FAT, 16'hffff);
        send(MODE_BYTE, 0);
        geometry(0, 100, 4096, 255, 5, 16'h8000);
        send(MODE_REWIND, 0);
        repeat (6) send(MODE_BYTE, 16'hffff);
        send(MODE_REWIND, 0);
        send(MODE_SECTOR, 0);
        send(MODE_SECTOR, 0);
        // Out of range sizes: clamped sector size and zero cluster size
        geometry(7, 9, 1, 0, 1000, 3);
        send(MODE_REWIND, 0);
        random_walk(20);
        geometry(7, 9, 8191, 2, 1000, 3);
        send(MODE_REWIND, 0);
        random_walk(10);

        // Random phases over several geometries
        for (int ph = 0; ph < 6; ph++)
        begin
            geometry($urandom, $urandom, $urandom_range(2, 24), $urandom_range(1, 4),
                     (ph == 5) ? 32'hffff_ffff : $urandom_range(50, 400),
                     (ph == 1) ? 16'h0 : 16'($urandom));
            quiet = (ph == 2);
            send(MODE_REWIND, 0);
            random_walk(165);
        end
        quiet = 0;

        drain();
        if (sb_chk.errors == 0 && sb_chk.pending.size() == 0)
            $display("fat16_file_read_sequencer: match");
        else
            $display("fat16_file_read_sequencer: mismatch");
        $finish;
    end

    // Watchdog
    initial
    begin
        #3000000;
        $display("fat16_file_read_sequencer: mismatch");
        $finish;
    end
endmodule
